// File: rtl/ebs_pkg.sv
package ebs_pkg;

   localparam int STORE_AW     = 17;
   localparam int TEXEL_W      = 48;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   // Angle pipeline layout: stage 0 takes the word, the longitude CORDIC runs in
   // stages 1..24, the square root in 1..15, the latitude CORDIC in 17..40.
   localparam int CORDIC_ITERS = 24;
   localparam int SQRT_BITS    = 15;
   localparam int LAT_SETUP    = SQRT_BITS + 1;
   localparam int LAT_LAST     = LAT_SETUP + CORDIC_ITERS;
   localparam int ANG_STAGES   = LAT_LAST + 2;

   localparam int FCH_STAGES   = 4;

   localparam int QUO_BITS     = 8;
   localparam int DIV_FIRST    = 4;
   localparam int BLD_STAGES   = DIV_FIRST + QUO_BITS + 1;

   localparam logic signed [25:0] HALF_TURN    = 26'sd8388608;
   localparam logic signed [25:0] QUARTER_TURN = 26'sd4194304;

   typedef enum logic [1:0] {
      CSR_MAP_WIDTH  = 2'd0,
      CSR_MAP_HEIGHT = 2'd1,
      CSR_MAX_VALUE  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [9:0]  width;
      logic [8:0]  height;
      logic [15:0] max_val;
   } cfg_type;

   typedef struct packed {
      logic                  cmd;
      logic [STORE_AW-1:0]   addr;
      logic [TEXEL_W-1:0]    texel;
      logic [24:0]           u;
      logic [24:0]           v;
   } ang_out_type;

   typedef struct packed {
      logic [7:0]            tx;
      logic [7:0]            ty;
      logic [TEXEL_W-1:0]    ul;
      logic [TEXEL_W-1:0]    ur;
      logic [TEXEL_W-1:0]    ll;
      logic [TEXEL_W-1:0]    lr;
   } fch_out_type;

   // Arctangent of 2^-i in units of 2^-24 turn, rounded.
   function automatic logic signed [25:0] atan_entry(input int idx);
      logic signed [25:0] r;
      case (idx)
         0:  r = 26'sd2097152;
         1:  r = 26'sd1238021;
         2:  r = 26'sd654136;
         3:  r = 26'sd332050;
         4:  r = 26'sd166669;
         5:  r = 26'sd83416;
         6:  r = 26'sd41718;
         7:  r = 26'sd20860;
         8:  r = 26'sd10430;
         9:  r = 26'sd5215;
         10: r = 26'sd2608;
         11: r = 26'sd1304;
         12: r = 26'sd652;
         13: r = 26'sd326;
         14: r = 26'sd163;
         15: r = 26'sd81;
         16: r = 26'sd41;
         17: r = 26'sd20;
         18: r = 26'sd10;
         19: r = 26'sd5;
         20: r = 26'sd3;
         21: r = 26'sd1;
         22: r = 26'sd1;
         default: r = 26'sd0;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/ebs_angle.sv
module ebs_angle (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 in_cmd,
   input  logic [16:0]          in_addr,
   input  logic [47:0]          in_texel,
   input  logic signed [15:0]   in_dx,
   input  logic signed [15:0]   in_dy,
   input  logic signed [15:0]   in_dz,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ebs_pkg::ang_out_type out_word
);
   import ebs_pkg::*;

   typedef struct packed {
      logic                 cmd;
      logic [16:0]          addr;
      logic [47:0]          texel;
      logic signed [29:0]   lon_x;
      logic signed [29:0]   lon_y;
      logic signed [25:0]   lon_a;
      logic                 lon_zero;
      logic [28:0]          sq_rem;
      logic [14:0]          sq_root;
      logic signed [15:0]   dz;
      logic signed [29:0]   lat_x;
      logic signed [29:0]   lat_y;
      logic signed [25:0]   lat_a;
      logic [24:0]          u;
      logic [24:0]          v;
   } ang_stage_type;

   localparam int LAST = ANG_STAGES - 1;

   ang_stage_type stage_ff [ANG_STAGES];
   ang_stage_type stage_in [ANG_STAGES];
   logic [ANG_STAGES-1:0] valid_ff;
   logic [ANG_STAGES:0]   adv;

   logic signed [15:0] dz_clamp;
   logic signed [31:0] dz_sq;
   logic signed [29:0] x_scaled;
   logic signed [29:0] y_scaled;

   assign adv[ANG_STAGES] = out_ready;
   for (genvar k = 0; k < ANG_STAGES; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   always_comb begin
      if (in_dz > 16'sd16384) begin
         dz_clamp = 16'sd16384;
      end else if (in_dz < -16'sd16384) begin
         dz_clamp = -16'sd16384;
      end else begin
         dz_clamp = in_dz;
      end
      dz_sq    = dz_clamp * dz_clamp;
      x_scaled = {{2{in_dx[15]}}, in_dx, 12'd0};
      y_scaled = {{2{in_dy[15]}}, in_dy, 12'd0};

      stage_in[0]          = '0;
      stage_in[0].cmd      = in_cmd;
      stage_in[0].addr     = in_addr;
      stage_in[0].texel    = in_texel;
      stage_in[0].dz       = dz_clamp;
      stage_in[0].sq_rem   = 29'(32'sd268435456 - dz_sq);
      stage_in[0].lon_zero = (in_dx == 16'sd0) && (in_dy == 16'sd0);
      // A vector in the left half plane is first turned by a quarter turn.
      if (in_dx < 16'sd0) begin
         if (in_dy >= 16'sd0) begin
            stage_in[0].lon_x = y_scaled;
            stage_in[0].lon_y = -x_scaled;
            stage_in[0].lon_a = QUARTER_TURN;
         end else begin
            stage_in[0].lon_x = -y_scaled;
            stage_in[0].lon_y = x_scaled;
            stage_in[0].lon_a = -QUARTER_TURN;
         end
      end else begin
         stage_in[0].lon_x = x_scaled;
         stage_in[0].lon_y = y_scaled;
         stage_in[0].lon_a = '0;
      end
   end

   for (genvar k = 1; k < LAST; k++) begin : g_stage
      localparam int LON_I = (k <= CORDIC_ITERS) ? k - 1 : 0;
      localparam int SQ_B  = (k <= SQRT_BITS) ? SQRT_BITS - k : 0;
      localparam int LAT_I = (k > LAT_SETUP) ? k - LAT_SETUP - 1 : 0;
      logic [30:0] trial;

      always_comb begin
         stage_in[k] = stage_ff[k-1];
         trial = (31'(stage_ff[k-1].sq_root) << (SQ_B + 1)) + (31'd1 << (2 * SQ_B));

         if (k <= CORDIC_ITERS) begin
            if (stage_ff[k-1].lon_y >= 0) begin
               stage_in[k].lon_x = stage_ff[k-1].lon_x + (stage_ff[k-1].lon_y >>> LON_I);
               stage_in[k].lon_y = stage_ff[k-1].lon_y - (stage_ff[k-1].lon_x >>> LON_I);
               stage_in[k].lon_a = stage_ff[k-1].lon_a + atan_entry(LON_I);
            end else begin
               stage_in[k].lon_x = stage_ff[k-1].lon_x - (stage_ff[k-1].lon_y >>> LON_I);
               stage_in[k].lon_y = stage_ff[k-1].lon_y + (stage_ff[k-1].lon_x >>> LON_I);
               stage_in[k].lon_a = stage_ff[k-1].lon_a - atan_entry(LON_I);
            end
         end

         // One root bit per stage, most significant first.
         if (k <= SQRT_BITS) begin
            if ({2'b00, stage_ff[k-1].sq_rem} >= trial) begin
               stage_in[k].sq_rem  = 29'({2'b00, stage_ff[k-1].sq_rem} - trial);
               stage_in[k].sq_root = stage_ff[k-1].sq_root | (15'd1 << SQ_B);
            end
         end

         if (k == LAT_SETUP) begin
            stage_in[k].lat_x = {3'b000, stage_ff[k-1].sq_root, 12'd0};
            stage_in[k].lat_y = {{2{stage_ff[k-1].dz[15]}}, stage_ff[k-1].dz, 12'd0};
            stage_in[k].lat_a = '0;
         end

         if (k > LAT_SETUP) begin
            if (stage_ff[k-1].lat_y >= 0) begin
               stage_in[k].lat_x = stage_ff[k-1].lat_x + (stage_ff[k-1].lat_y >>> LAT_I);
               stage_in[k].lat_y = stage_ff[k-1].lat_y - (stage_ff[k-1].lat_x >>> LAT_I);
               stage_in[k].lat_a = stage_ff[k-1].lat_a + atan_entry(LAT_I);
            end else begin
               stage_in[k].lat_x = stage_ff[k-1].lat_x - (stage_ff[k-1].lat_y >>> LAT_I);
               stage_in[k].lat_y = stage_ff[k-1].lat_y + (stage_ff[k-1].lat_x >>> LAT_I);
               stage_in[k].lat_a = stage_ff[k-1].lat_a - atan_entry(LAT_I);
            end
         end
      end
   end

   logic signed [25:0] lon_c;
   logic signed [25:0] lat_c;
   logic signed [25:0] u_full;
   logic signed [25:0] v_full;

   always_comb begin
      if (stage_ff[LAST-1].lon_zero) begin
         lon_c = '0;
      end else if (stage_ff[LAST-1].lon_a > HALF_TURN) begin
         lon_c = HALF_TURN;
      end else if (stage_ff[LAST-1].lon_a < -HALF_TURN) begin
         lon_c = -HALF_TURN;
      end else begin
         lon_c = stage_ff[LAST-1].lon_a;
      end
      if (stage_ff[LAST-1].lat_a > QUARTER_TURN) begin
         lat_c = QUARTER_TURN;
      end else if (stage_ff[LAST-1].lat_a < -QUARTER_TURN) begin
         lat_c = -QUARTER_TURN;
      end else begin
         lat_c = stage_ff[LAST-1].lat_a;
      end
      u_full = lon_c + HALF_TURN;
      v_full = HALF_TURN - (lat_c <<< 1);
      stage_in[LAST]   = stage_ff[LAST-1];
      stage_in[LAST].u = u_full[24:0];
      stage_in[LAST].v = v_full[24:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < ANG_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < ANG_STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid      = valid_ff[LAST];
   assign out_word.cmd   = stage_ff[LAST].cmd;
   assign out_word.addr  = stage_ff[LAST].addr;
   assign out_word.texel = stage_ff[LAST].texel;
   assign out_word.u     = stage_ff[LAST].u;
   assign out_word.v     = stage_ff[LAST].v;

endmodule

// File: rtl/ebs_fetch.sv
module ebs_fetch (
   input  logic                 clock,
   input  logic                 reset,
   input  ebs_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ebs_pkg::ang_out_type in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output ebs_pkg::fch_out_type out_word
);
   import ebs_pkg::*;

   logic [FCH_STAGES-1:0] valid_ff;
   logic [FCH_STAGES:0]   adv;

   // Two copies of the texel store, each with two read ports: the upper row
   // pair is read from one copy and the lower row pair from the other.
   logic [TEXEL_W-1:0] mem_top [2**STORE_AW];
   logic [TEXEL_W-1:0] mem_bot [2**STORE_AW];

   logic                 cmd0_ff, cmd1_ff, cmd2_ff, cmd3_ff;
   logic [STORE_AW-1:0]  addr0_ff, addr1_ff, addr2_ff;
   logic [TEXEL_W-1:0]   texel0_ff, texel1_ff, texel2_ff;
   logic [34:0]          xp0_ff, xp0_in;
   logic [33:0]          yp0_ff, yp0_in;
   logic [7:0]           tx1_ff, tx1_in, ty1_ff, ty1_in;
   logic [9:0]           col0_ff, col0_in, col1_ff, col1_in;
   logic [8:0]           row0_ff, row0_in, row1_ff, row1_in;
   logic [7:0]           tx2_ff, ty2_ff, tx3_ff, ty3_ff;
   logic [3:0][STORE_AW-1:0] rd_addr_ff, rd_addr_in;
   logic [TEXEL_W-1:0]   ul_ff, ur_ff, ll_ff, lr_ff;

   logic signed [19:0]   x8;
   logic signed [18:0]   y8;
   logic signed [11:0]   left, left1;
   logic signed [10:0]   top, top1;
   logic [18:0]          base0, base1;

   // A write word in the last stage leaves no result, so it counts as empty.
   assign adv[FCH_STAGES]   = out_ready;
   assign adv[FCH_STAGES-1] = !(valid_ff[FCH_STAGES-1] && (cmd3_ff == CMD_SAMPLE))
                              || adv[FCH_STAGES];
   for (genvar k = 0; k < FCH_STAGES - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   always_comb begin
      xp0_in = 35'(in_word.u) * 35'(cfg.width);
      yp0_in = 34'(in_word.v) * 34'(cfg.height);
   end

   // The integer column lies in -1..width-1 and the row in -1..height-1, so
   // wrapping and clamping need only one compare each.
   always_comb begin
      x8      = signed'({1'b0, xp0_ff[34:16]}) - 20'sd128;
      y8      = signed'({1'b0, yp0_ff[33:16]}) - 19'sd128;
      left    = x8[19:8];
      left1   = left + 12'sd1;
      top     = y8[18:8];
      top1    = top + 11'sd1;
      tx1_in  = x8[7:0];
      ty1_in  = y8[7:0];
      col0_in = left[11] ? cfg.width - 10'd1 : left[9:0];
      col1_in = (left1 == {2'b00, cfg.width}) ? 10'd0 : left1[9:0];
      row0_in = top[10] ? 9'd0 : top[8:0];
      row1_in = (top1 == {2'b00, cfg.height}) ? cfg.height - 9'd1 : top1[8:0];
   end

   always_comb begin
      base0         = 19'(row0_ff) * 19'(cfg.width);
      base1         = 19'(row1_ff) * 19'(cfg.width);
      rd_addr_in[0] = STORE_AW'(base0 + 19'(col0_ff));
      rd_addr_in[1] = STORE_AW'(base0 + 19'(col1_ff));
      rd_addr_in[2] = STORE_AW'(base1 + 19'(col0_ff));
      rd_addr_in[3] = STORE_AW'(base1 + 19'(col1_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < FCH_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         cmd0_ff   <= in_word.cmd;
         addr0_ff  <= in_word.addr;
         texel0_ff <= in_word.texel;
         xp0_ff    <= xp0_in;
         yp0_ff    <= yp0_in;
      end
      if (adv[1]) begin
         cmd1_ff   <= cmd0_ff;
         addr1_ff  <= addr0_ff;
         texel1_ff <= texel0_ff;
         tx1_ff    <= tx1_in;
         ty1_ff    <= ty1_in;
         col0_ff   <= col0_in;
         col1_ff   <= col1_in;
         row0_ff   <= row0_in;
         row1_ff   <= row1_in;
      end
      if (adv[2]) begin
         cmd2_ff    <= cmd1_ff;
         addr2_ff   <= addr1_ff;
         texel2_ff  <= texel1_ff;
         tx2_ff     <= tx1_ff;
         ty2_ff     <= ty1_ff;
         rd_addr_ff <= rd_addr_in;
      end
      if (adv[3]) begin
         cmd3_ff <= cmd2_ff;
         tx3_ff  <= tx2_ff;
         ty3_ff  <= ty2_ff;
      end
   end

   // Writes and reads happen as words enter the last stage, so they keep
   // the order in which the words were accepted.
   always_ff @(posedge clock) begin
      if (adv[3] && valid_ff[2]) begin
         if (cmd2_ff == CMD_WRITE) begin
            mem_top[addr2_ff] <= texel2_ff;
         end
         ul_ff <= mem_top[rd_addr_ff[0]];
         ur_ff <= mem_top[rd_addr_ff[1]];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3] && valid_ff[2]) begin
         if (cmd2_ff == CMD_WRITE) begin
            mem_bot[addr2_ff] <= texel2_ff;
         end
         ll_ff <= mem_bot[rd_addr_ff[2]];
         lr_ff <= mem_bot[rd_addr_ff[3]];
      end
   end

   assign out_valid   = valid_ff[FCH_STAGES-1] && (cmd3_ff == CMD_SAMPLE);
   assign out_word.tx = tx3_ff;
   assign out_word.ty = ty3_ff;
   assign out_word.ul = ul_ff;
   assign out_word.ur = ur_ff;
   assign out_word.ll = ll_ff;
   assign out_word.lr = lr_ff;

endmodule

// File: rtl/ebs_blend.sv
module ebs_blend (
   input  logic                 clock,
   input  logic                 reset,
   input  ebs_pkg::cfg_type     cfg,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  ebs_pkg::fch_out_type in_word,
   output logic                 out_valid,
   input  logic                 out_ready,
   output logic [7:0]           out_red,
   output logic [7:0]           out_green,
   output logic [7:0]           out_blue
);
   import ebs_pkg::*;

   typedef struct packed {
      logic [7:0]        ty;
      logic [2:0][23:0]  up;
      logic [2:0][23:0]  lo;
      logic [2:0][31:0]  acc;
      logic [2:0][24:0]  rem;
      logic [2:0][7:0]   quo;
      logic [2:0]        over;
   } bld_stage_type;

   localparam int LAST = BLD_STAGES - 1;

   bld_stage_type stage_ff [BLD_STAGES];
   bld_stage_type stage_in [BLD_STAGES];
   logic [BLD_STAGES-1:0] valid_ff;
   logic [BLD_STAGES:0]   adv;

   logic [8:0]  wx0, wx1, wy0, wy1;
   logic [2:0][15:0] c_ul, c_ur, c_ll, c_lr;
   logic [2:0][41:0] num;

   assign adv[BLD_STAGES] = out_ready;
   for (genvar k = 0; k < BLD_STAGES; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   // Channel 0 is red, held in the top 16 bits of a texel.
   always_comb begin
      wx1 = {1'b0, in_word.tx};
      wx0 = 9'd256 - wx1;
      stage_in[0]    = '0;
      stage_in[0].ty = in_word.ty;
      for (int ch = 0; ch < 3; ch++) begin
         c_ul[ch] = in_word.ul[TEXEL_W-1-16*ch -: 16];
         c_ur[ch] = in_word.ur[TEXEL_W-1-16*ch -: 16];
         c_ll[ch] = in_word.ll[TEXEL_W-1-16*ch -: 16];
         c_lr[ch] = in_word.lr[TEXEL_W-1-16*ch -: 16];
         stage_in[0].up[ch] = 24'(25'(c_ul[ch]) * 25'(wx0) + 25'(c_ur[ch]) * 25'(wx1));
         stage_in[0].lo[ch] = 24'(25'(c_ll[ch]) * 25'(wx0) + 25'(c_lr[ch]) * 25'(wx1));
      end
   end

   always_comb begin
      wy1 = {1'b0, stage_ff[0].ty};
      wy0 = 9'd256 - wy1;
      stage_in[1] = stage_ff[0];
      for (int ch = 0; ch < 3; ch++) begin
         stage_in[1].acc[ch] = 32'(34'(stage_ff[0].up[ch]) * 34'(wy0)
                                 + 34'(stage_ff[0].lo[ch]) * 34'(wy1));
      end
   end

   // Rounding: floor((510*acc + max*2^16) / (max*2^17)) equals the rounded
   // quotient, and the 2^17 part is dropped before the divide.
   always_comb begin
      stage_in[2] = stage_ff[1];
      for (int ch = 0; ch < 3; ch++) begin
         num[ch] = 42'(stage_ff[1].acc[ch]) * 42'd510 + {10'd0, cfg.max_val, 16'd0};
         stage_in[2].rem[ch] = num[ch][41:17];
      end
   end

   always_comb begin
      stage_in[3] = stage_ff[2];
      for (int ch = 0; ch < 3; ch++) begin
         stage_in[3].over[ch] = stage_ff[2].rem[ch] >= {1'b0, cfg.max_val, 8'd0};
         stage_in[3].quo[ch]  = '0;
      end
   end

   for (genvar k = DIV_FIRST; k < LAST; k++) begin : g_div
      localparam int B = DIV_FIRST + QUO_BITS - 1 - k;
      logic [24:0] dsh;

      always_comb begin
         dsh = 25'(cfg.max_val) << B;
         stage_in[k] = stage_ff[k-1];
         for (int ch = 0; ch < 3; ch++) begin
            if (stage_ff[k-1].rem[ch] >= dsh) begin
               stage_in[k].rem[ch]    = stage_ff[k-1].rem[ch] - dsh;
               stage_in[k].quo[ch][B] = 1'b1;
            end
         end
      end
   end

   always_comb begin
      stage_in[LAST] = stage_ff[LAST-1];
      for (int ch = 0; ch < 3; ch++) begin
         if (stage_ff[LAST-1].over[ch]) begin
            stage_in[LAST].quo[ch] = 8'hFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < BLD_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < BLD_STAGES; k++) begin
         if (adv[k]) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   assign out_valid = valid_ff[LAST];
   assign out_red   = stage_ff[LAST].quo[0];
   assign out_green = stage_ff[LAST].quo[1];
   assign out_blue  = stage_ff[LAST].quo[2];

endmodule

// File: rtl/equirect_bilinear_sampler_unit.sv
// Equirectangular colour map sampler with bilinear filtering.
// Request channel (req_*): one word per valid/ready handshake. req_cmd = 0
// stores a 3 x 16-bit texel at req_texel_address and returns nothing;
// req_cmd = 1 turns the Q1.14 direction into longitude and latitude, reads
// the four neighboring texels and blends them.
// Result channel (rsp_*): one 8-bit RGB word per sample, in request order.
// Configuration (csr_*): map width, map height and channel full scale,
// written with csr_wr_en; change them only while no word is in flight.
// Throughput is one word per cycle while rsp_ready is high. A sample passes
// through 42 stages for the square root and the two 24-step CORDIC chains,
// 4 for coordinates and the texel store read, and 13 for the blend and the
// 8-step restoring divide by full scale, before it shows on rsp_valid.
// When rsp_ready is low, words close up behind the output register and the
// request side keeps taking words until every stage holds one.
// Reset empties the pipeline and loads width 512, height 256, full scale
// 255. The texel store is not cleared: sample only texels already written.
module equirect_bilinear_sampler_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic                req_cmd,
   input  logic [16:0]         req_texel_address,
   input  logic [15:0]         req_texel_red,
   input  logic [15:0]         req_texel_green,
   input  logic [15:0]         req_texel_blue,
   input  logic signed [15:0]  req_dir_x,
   input  logic signed [15:0]  req_dir_y,
   input  logic signed [15:0]  req_dir_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_red,
   output logic [7:0]          rsp_green,
   output logic [7:0]          rsp_blue,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_wdata
);
   import ebs_pkg::*;

   logic [9:0]  width_ff;
   logic [8:0]  height_ff;
   logic [15:0] maxval_ff;
   cfg_type     cfg;

   logic        ang_valid, ang_ready;
   ang_out_type ang_word;
   logic        fch_valid, fch_ready;
   fch_out_type fch_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 10'd512;
         height_ff <= 9'd256;
         maxval_ff <= 16'd255;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MAP_WIDTH:  width_ff  <= csr_wdata[9:0];
            CSR_MAP_HEIGHT: height_ff <= csr_wdata[8:0];
            CSR_MAX_VALUE:  maxval_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A zero size or full scale behaves as one.
   always_comb begin
      cfg.width   = (width_ff == 10'd0) ? 10'd1 : width_ff;
      cfg.height  = (height_ff == 9'd0) ? 9'd1 : height_ff;
      cfg.max_val = (maxval_ff == 16'd0) ? 16'd1 : maxval_ff;
   end

   ebs_angle u_angle (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_cmd    (req_cmd),
      .in_addr   (req_texel_address),
      .in_texel  ({req_texel_red, req_texel_green, req_texel_blue}),
      .in_dx     (req_dir_x),
      .in_dy     (req_dir_y),
      .in_dz     (req_dir_z),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_word  (ang_word)
   );

   ebs_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_word   (ang_word),
      .out_valid (fch_valid),
      .out_ready (fch_ready),
      .out_word  (fch_word)
   );

   ebs_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (fch_valid),
      .in_ready  (fch_ready),
      .in_word   (fch_word),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_red   (rsp_red),
      .out_green (rsp_green),
      .out_blue  (rsp_blue)
   );

   // With the output register empty, every stage behind it can move.
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side blocked with an empty output register");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result word present right after reset");

   a_inner_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> (ang_ready && fch_ready))
      else $error("inner stage stalled with an empty output register");

endmodule
